### sv/cnms_pkg.sv
package cnms_pkg;

  // Threshold register: unsigned Q1.8, raw values 0 to 511.
  localparam int unsigned THR_W     = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  // Fraction bits of the threshold.
  localparam int unsigned FRAC_W    = 8;

  // Object class width.
  localparam int unsigned CLASS_W   = 8;

  // Status of the shared overlap unit, seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic res_valid;
    logic suppress;
  } iou_status_t;

endpackage

### sv/cnms_iou.sv
// Shared overlap test: one stored box per cycle against the held candidate.
// Three stages: overlap and area products, union, threshold compare.
module cnms_iou #(
  parameter int unsigned CB = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [CB-1:0]                 cand_left_i,
  input  logic [CB-1:0]                 cand_top_i,
  input  logic [CB-1:0]                 cand_right_i,
  input  logic [CB-1:0]                 cand_bottom_i,
  input  logic [cnms_pkg::CLASS_W-1:0]  cand_class_i,
  input  logic [2*CB-1:0]               cand_area_i,
  input  logic [cnms_pkg::THR_W-1:0]    thr_i,
  input  logic [CB-1:0]                 ent_left_i,
  input  logic [CB-1:0]                 ent_top_i,
  input  logic [CB-1:0]                 ent_right_i,
  input  logic [CB-1:0]                 ent_bottom_i,
  input  logic [cnms_pkg::CLASS_W-1:0]  ent_class_i,
  output cnms_pkg::iou_status_t         status_o
);

  localparam int unsigned AREA_W = 2 * CB;
  localparam int unsigned UNI_W  = AREA_W + 1;
  localparam int unsigned CMP_W  = UNI_W + cnms_pkg::THR_W;

  // Intersection edges and spans.
  logic [CB-1:0] ov_l, ov_t, ov_r, ov_b;
  logic [CB-1:0] ov_w, ov_h, ent_w, ent_h;

  always_comb begin
    ov_l  = (cand_left_i  > ent_left_i)   ? cand_left_i   : ent_left_i;
    ov_t  = (cand_top_i   > ent_top_i)    ? cand_top_i    : ent_top_i;
    ov_r  = (cand_right_i < ent_right_i)  ? cand_right_i  : ent_right_i;
    ov_b  = (cand_bottom_i < ent_bottom_i) ? cand_bottom_i : ent_bottom_i;
    ov_w  = (ov_r > ov_l) ? ov_r - ov_l : '0;
    ov_h  = (ov_b > ov_t) ? ov_b - ov_t : '0;
    ent_w = (ent_right_i > ent_left_i) ? ent_right_i - ent_left_i : '0;
    ent_h = (ent_bottom_i > ent_top_i) ? ent_bottom_i - ent_top_i : '0;
  end

  // Stage A: products and class match.
  logic              va_q;
  logic              same_a_q;
  logic [AREA_W-1:0] inter_a_q, ent_area_a_q;

  always_ff @(posedge clk_i) begin
    same_a_q     <= (cand_class_i == ent_class_i);
    inter_a_q    <= AREA_W'(ov_w * ov_h);
    ent_area_a_q <= AREA_W'(ent_w * ent_h);
  end

  // Stage B: union of the two areas.
  logic              vb_q;
  logic              same_b_q;
  logic [AREA_W-1:0] inter_b_q;
  logic [UNI_W-1:0]  uni_b_q;

  always_ff @(posedge clk_i) begin
    same_b_q  <= same_a_q;
    inter_b_q <= inter_a_q;
    uni_b_q   <= UNI_W'(cand_area_i) + UNI_W'(ent_area_a_q) - UNI_W'(inter_a_q);
  end

  // Stage C: inter * 256 against threshold * union.
  logic             vc_q;
  logic             supp_c_q;
  logic [CMP_W-1:0] lhs, rhs;

  always_comb begin
    lhs = CMP_W'({inter_b_q, {cnms_pkg::FRAC_W{1'b0}}});
    rhs = CMP_W'(thr_i) * CMP_W'(uni_b_q);
  end

  always_ff @(posedge clk_i) begin
    supp_c_q <= same_b_q && (lhs > rhs);
  end

  // Valid chain through the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign status_o.busy      = va_q | vb_q;
  assign status_o.res_valid = vc_q;
  assign status_o.suppress  = supp_c_q;

endmodule

### sv/class_aware_box_nms.sv
// Greedy per-class non-maximum suppression.
// Candidate boxes enter on the input channel (in_valid_i / in_ready_o),
// already sorted by falling confidence. Each transfer is checked against
// every box picked so far in the frame; a stored box of the same class whose
// intersection-over-union exceeds the threshold suppresses the candidate.
// Kept boxes are appended to a list of MAX_PICKED entries. new_frame_i
// empties that list before its box is checked.
// One result per candidate leaves on the output channel (out_valid_o /
// out_ready_i): keep_o, picked_count_o and overflow_o.
// After the input transfer the block computes the candidate area, then reads
// the stored boxes from the list memory, one per cycle, into the shared
// overlap unit, lets the read register and the unit pipeline drain, and then
// loads the output register. The block takes one candidate at a time and
// accepts the next only once the last result is in the output register.
// The result sits in an output register; while the receiver stalls, the
// block takes the next candidate and holds its result until the output frees.
// The user writes the threshold register with cfg_we_i only while the block
// is idle; the block itself does not enforce this.
// Reset empties the list and loads the threshold with 115 (about 0.45).
module class_aware_box_nms #(
  parameter int unsigned MAX_PICKED = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [cnms_pkg::THR_W-1:0]                 cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [COORD_BITS-1:0]                      box_left_i,
  input  logic [COORD_BITS-1:0]                      box_top_i,
  input  logic [COORD_BITS-1:0]                      box_right_i,
  input  logic [COORD_BITS-1:0]                      box_bottom_i,
  input  logic [cnms_pkg::CLASS_W-1:0]               class_id_i,
  input  logic                                       new_frame_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic                                       keep_o,
  output logic [$clog2(MAX_PICKED+1)-1:0]            picked_count_o,
  output logic                                       overflow_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_PICKED + 1);
  localparam int unsigned AW     = (MAX_PICKED > 1) ? $clog2(MAX_PICKED) : 1;
  localparam int unsigned ENT_W  = 4 * CB + cnms_pkg::CLASS_W;
  localparam int unsigned AREA_W = 2 * CB;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_AREA = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  // Threshold register.
  logic [cnms_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= cnms_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Handshake and sequencer conditions.
  logic in_fire, issue, fin_fire, store;
  logic [CNT_W-1:0] iss_q, count_q;
  logic rd_valid_q;
  logic keep_q;
  cnms_pkg::iou_status_t status;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_SCAN) && (iss_q < count_q);
  assign fin_fire   = (state_q == S_FIN) && (!out_valid_o || out_ready_i);
  assign store      = fin_fire && keep_q && (count_q < CNT_W'(MAX_PICKED));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_AREA;
      end
      S_AREA: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rd_valid_q && !status.busy) state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Candidate held for the whole check.
  logic [CB-1:0]               cand_l_q, cand_t_q, cand_r_q, cand_b_q;
  logic [cnms_pkg::CLASS_W-1:0] cand_c_q;
  logic [AREA_W-1:0]           cand_area_q;
  logic [CB-1:0]               cand_w, cand_h;

  assign cand_w = (cand_r_q > cand_l_q) ? cand_r_q - cand_l_q : '0;
  assign cand_h = (cand_b_q > cand_t_q) ? cand_b_q - cand_t_q : '0;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cand_l_q <= box_left_i;
      cand_t_q <= box_top_i;
      cand_r_q <= box_right_i;
      cand_b_q <= box_bottom_i;
      cand_c_q <= class_id_i;
    end
    if (state_q == S_AREA) begin
      cand_area_q <= AREA_W'(cand_w * cand_h);
    end
  end

  // List fill count, scan pointer and keep flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      iss_q      <= '0;
      rd_valid_q <= 1'b0;
      keep_q     <= 1'b0;
    end else begin
      rd_valid_q <= issue;
      if (in_fire) begin
        iss_q  <= '0;
        keep_q <= 1'b1;
        if (new_frame_i) count_q <= '0;
      end else begin
        if (issue) iss_q <= iss_q + 1'b1;
        if (status.res_valid && status.suppress) keep_q <= 1'b0;
        if (store) count_q <= count_q + 1'b1;
      end
    end
  end

  // Picked-box list memory with registered read.
  logic [ENT_W-1:0] mem_q [MAX_PICKED];
  logic [ENT_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[count_q[AW-1:0]] <= {cand_c_q, cand_b_q, cand_r_q, cand_t_q, cand_l_q};
    end
    if (issue) begin
      rd_q <= mem_q[iss_q[AW-1:0]];
    end
  end

  cnms_iou #(
    .CB(CB)
  ) u_iou (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rd_valid_q),
    .cand_left_i   (cand_l_q),
    .cand_top_i    (cand_t_q),
    .cand_right_i  (cand_r_q),
    .cand_bottom_i (cand_b_q),
    .cand_class_i  (cand_c_q),
    .cand_area_i   (cand_area_q),
    .thr_i         (thr_q),
    .ent_left_i    (rd_q[CB-1:0]),
    .ent_top_i     (rd_q[2*CB-1:CB]),
    .ent_right_i   (rd_q[3*CB-1:2*CB]),
    .ent_bottom_i  (rd_q[4*CB-1:3*CB]),
    .ent_class_i   (rd_q[ENT_W-1:4*CB]),
    .status_o      (status)
  );

  // Output register.
  logic             out_valid_q, keep_out_q, ovf_q;
  logic [CNT_W-1:0] cnt_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      keep_out_q <= keep_q;
      ovf_q      <= keep_q && !store;
      cnt_out_q  <= store ? count_q + 1'b1 : count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign keep_o         = keep_out_q;
  assign overflow_o     = ovf_q;
  assign picked_count_o = cnt_out_q;

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PICKED))
    else $error("picked list count beyond capacity");

  // An overflow is only reported for a kept box with the list full.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (keep_o && picked_count_o == CNT_W'(MAX_PICKED)))
    else $error("overflow reported without a full list");

  // Overlap results arrive only while the list is being scanned.
  a_res_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_valid |-> (state_q == S_SCAN))
    else $error("overlap result outside the scan");

  // A new result is loaded only when the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(picked_count_o)))
    else $error("pending result overwritten");

endmodule

### bench/tb_class_aware_box_nms.sv
`timescale 1ns / 100ps

module tb_class_aware_box_nms;

  localparam int unsigned THR_W           = cnms_pkg::THR_W;
  localparam int unsigned CLASS_W         = cnms_pkg::CLASS_W;
  localparam logic [THR_W-1:0] THR_RESET  = cnms_pkg::THR_RESET;
  localparam int unsigned LIST_DEPTH      = 64;
  localparam int unsigned COORD_W         = 12;
  localparam int unsigned COUNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int unsigned COORD_MAX       = (1 << COORD_W) - 1;
  localparam int unsigned ITEMS_PER_PHASE = 128;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam longint unsigned TIMEOUT_NS  = 64'd20_000_000;

  typedef struct packed {
    logic [COORD_W-1:0]   x_lo;
    logic [COORD_W-1:0]   y_lo;
    logic [COORD_W-1:0]   x_hi;
    logic [COORD_W-1:0]   y_hi;
    logic [CLASS_W-1:0]   cls;
  } box_t;

  typedef struct packed {
    logic               keep;
    logic [COUNT_W-1:0] picked;
    logic               ovf;
  } verdict_t;

  // Receiver behavior for one stretch of cycles.
  typedef enum int unsigned {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PATTERN,
    READY_COIN
  } ready_mode_e;

  // Tracks the picked list and threshold, and holds the verdicts still owed by the block.
  class nms_verdict_board;
    logic [THR_W-1:0] threshold;
    box_t             picked_list[LIST_DEPTH];
    int unsigned      picked_n;
    verdict_t         expected_verdicts[$];
    int unsigned      failures;

    function new();
      threshold = THR_RESET;
      picked_n  = 0;
      failures  = 0;
    endfunction

    static function longint unsigned extent(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
      return (hi > lo) ? longint'(hi - lo) : 64'd0;
    endfunction

    static function longint unsigned box_area(box_t b);
      return extent(b.x_lo, b.x_hi) * extent(b.y_lo, b.y_hi);
    endfunction

    static function longint unsigned overlap_area(box_t p, box_t q);
      logic [COORD_W-1:0] l, t, r, b;
      l = (p.x_lo > q.x_lo) ? p.x_lo : q.x_lo;
      t = (p.y_lo > q.y_lo) ? p.y_lo : q.y_lo;
      r = (p.x_hi < q.x_hi) ? p.x_hi : q.x_hi;
      b = (p.y_hi < q.y_hi) ? p.y_hi : q.y_hi;
      return extent(l, r) * extent(t, b);
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = value;
    endfunction

    // Runs greedy suppression for one accepted candidate and queues its verdict.
    function void note_box(box_t cand, logic new_frame);
      verdict_t          v;
      longint unsigned   cand_area;
      longint unsigned   inter;
      longint unsigned   uni_area;
      logic              keep;
      int unsigned       j;
      if (new_frame) begin
        picked_n = 0;
      end
      cand_area = box_area(cand);
      keep = 1'b1;
      for (j = 0; j < picked_n; j++) begin
        if (picked_list[j].cls == cand.cls) begin
          inter    = overlap_area(cand, picked_list[j]);
          uni_area = cand_area + box_area(picked_list[j]) - inter;
          if (inter * 64'd256 > 64'(threshold) * uni_area) begin
            keep = 1'b0;
          end
        end
      end
      v.ovf = 1'b0;
      if (keep) begin
        if (picked_n < LIST_DEPTH) begin
          picked_list[picked_n] = cand;
          picked_n++;
        end else begin
          v.ovf = 1'b1;
        end
      end
      v.keep   = keep;
      v.picked = COUNT_W'(picked_n);
      expected_verdicts.insert(expected_verdicts.size(), v);
    endfunction

    // Compares one result transfer against the oldest outstanding verdict.
    function void check_verdict(logic keep, logic [COUNT_W-1:0] picked, logic ovf);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: result transfer with no candidate outstanding", $time);
        end
        return;
      end
      want = expected_verdicts[0];
      expected_verdicts.delete(0);
      if (want.keep !== keep || want.picked !== picked || want.ovf !== ovf) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: mismatch keep %0b/%0b picked_count %0d/%0d overflow %0b/%0b (exp/act)",
                   $time, want.keep, keep, want.picked, picked, want.ovf, ovf);
        end
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [THR_W-1:0]     cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [COORD_W-1:0]   box_left_i    = '0;
  logic [COORD_W-1:0]   box_top_i     = '0;
  logic [COORD_W-1:0]   box_right_i   = '0;
  logic [COORD_W-1:0]   box_bottom_i  = '0;
  logic [CLASS_W-1:0]   class_id_i    = '0;
  logic                 new_frame_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic                 keep_o;
  logic [COUNT_W-1:0]   picked_count_o;
  logic                 overflow_o;

  nms_verdict_board sb = new();

  box_t        frame_boxes[$];
  int unsigned burst_left   = 1;
  bit          hold_request = 1'b0;

  class_aware_box_nms #(
    .MAX_PICKED (LIST_DEPTH),
    .COORD_BITS (COORD_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .box_left_i     (box_left_i),
    .box_top_i      (box_top_i),
    .box_right_i    (box_right_i),
    .box_bottom_i   (box_bottom_i),
    .class_id_i     (class_id_i),
    .new_frame_i    (new_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .keep_o         (keep_o),
    .picked_count_o (picked_count_o),
    .overflow_o     (overflow_o)
  );

  // Clock: 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      sb.check_verdict(keep_o, picked_count_o, overflow_o);
    end
  end

  // Receiver: stretches of different stall patterns, plus a long hold-off on request.
  initial begin
    ready_mode_e mode;
    int unsigned seg;
    int unsigned k;
    logic [7:0]  pattern;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(posedge clk_i);
        end
        hold_request = 1'b0;
      end
      mode    = ready_mode_e'($urandom_range(0, 3));
      seg     = $urandom_range(16, 160);
      pattern = 8'($urandom_range(1, 255));
      for (k = 0; k < seg && !hold_request; k++) begin
        case (mode)
          READY_ALWAYS: begin
            out_ready_i <= 1'b1;
          end
          READY_MOSTLY: begin
            out_ready_i <= ($urandom_range(0, 3) != 0);
          end
          READY_PATTERN: begin
            out_ready_i <= pattern[k % 8];
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 1) == 0);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_class_aware_box_nms NOT OK");
    $finish;
  end

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > int'(COORD_MAX)) begin
      return COORD_W'(COORD_MAX);
    end
    return COORD_W'(v);
  endfunction

  // Moves an edge by up to m pixels in either direction.
  function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base, int unsigned m);
    int delta;
    delta = int'($urandom_range(0, m));
    if ($urandom_range(0, 1) == 0) begin
      delta = -delta;
    end
    return clamp_coord(int'(base) + delta);
  endfunction

  function automatic logic [CLASS_W-1:0] pick_class(bit spread);
    if (spread || $urandom_range(0, 4) == 0) begin
      return CLASS_W'($urandom_range(0, 255));
    end
    return CLASS_W'($urandom_range(0, 3));
  endfunction

  function automatic box_t mk_box(input int xl, input int yl, input int xh, input int yh,
                                  input int cls);
    box_t bx;
    bx.x_lo = COORD_W'(xl);
    bx.y_lo = COORD_W'(yl);
    bx.x_hi = COORD_W'(xh);
    bx.y_hi = COORD_W'(yh);
    bx.cls  = CLASS_W'(cls);
    return bx;
  endfunction

  // Random candidate: often near-copies of boxes already sent in the frame, so that
  // overlap ratios land close to the threshold, plus fresh, huge and arbitrary boxes.
  function automatic box_t make_box(bit spread);
    box_t        bx;
    box_t        base;
    int unsigned roll;
    int unsigned w;
    int unsigned h;
    roll = $urandom_range(0, 99);
    if (frame_boxes.size() != 0 && roll < (spread ? 5 : 45)) begin
      base = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
      w = (base.x_hi > base.x_lo) ? base.x_hi - base.x_lo : 0;
      h = (base.y_hi > base.y_lo) ? base.y_hi - base.y_lo : 0;
      bx.x_lo = nudge(base.x_lo, w / 4 + 1);
      bx.x_hi = nudge(base.x_hi, w / 4 + 1);
      bx.y_lo = nudge(base.y_lo, h / 4 + 1);
      bx.y_hi = nudge(base.y_hi, h / 4 + 1);
      bx.cls  = ($urandom_range(0, 6) == 0) ? pick_class(1'b0) : base.cls;
    end else if (roll < 88) begin
      w = $urandom_range(0, 400);
      h = $urandom_range(0, 400);
      bx.x_lo = COORD_W'($urandom_range(0, COORD_MAX - w));
      bx.y_lo = COORD_W'($urandom_range(0, COORD_MAX - h));
      bx.x_hi = bx.x_lo + COORD_W'(w);
      bx.y_hi = bx.y_lo + COORD_W'(h);
      bx.cls  = pick_class(spread);
    end else if (roll < 93) begin
      bx.x_lo = COORD_W'($urandom_range(0, 300));
      bx.y_lo = COORD_W'($urandom_range(0, 300));
      bx.x_hi = COORD_W'($urandom_range(COORD_MAX - 400, COORD_MAX));
      bx.y_hi = COORD_W'($urandom_range(COORD_MAX - 400, COORD_MAX));
      bx.cls  = pick_class(spread);
    end else begin
      // Arbitrary edges; about half of these come out reversed.
      bx.x_lo = COORD_W'($urandom_range(0, COORD_MAX));
      bx.y_lo = COORD_W'($urandom_range(0, COORD_MAX));
      bx.x_hi = COORD_W'($urandom_range(0, COORD_MAX));
      bx.y_hi = COORD_W'($urandom_range(0, COORD_MAX));
      bx.cls  = CLASS_W'($urandom_range(0, 255));
    end
    return bx;
  endfunction

  // Offers one candidate and waits for its transfer; then either keeps valid up for the
  // next one in the burst or drops it for a random gap.
  task automatic send_box(input box_t bx, input logic fs);
    in_valid_i    <= 1'b1;
    box_left_i    <= bx.x_lo;
    box_top_i     <= bx.y_lo;
    box_right_i   <= bx.x_hi;
    box_bottom_i  <= bx.y_hi;
    class_id_i    <= bx.cls;
    new_frame_i   <= fs;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    sb.note_box(bx, fs);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
  endtask

  // Stops offering and waits until every outstanding verdict has arrived.
  task automatic wait_idle();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end
    while (sb.expected_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(value);
  endtask

  // Edge cases at the reset threshold.
  task automatic run_directed();
    // Full-frame box, an exact duplicate, and the same box in another class.
    send_box(mk_box(0, 0, COORD_MAX, COORD_MAX, 0), 1'b1);
    send_box(mk_box(0, 0, COORD_MAX, COORD_MAX, 0), 1'b0);
    send_box(mk_box(0, 0, COORD_MAX, COORD_MAX, 255), 1'b0);
    // Reversed edges give zero area; a zero-width box then meets it with zero union.
    send_box(mk_box(COORD_MAX, COORD_MAX, 0, 0, 0), 1'b0);
    send_box(mk_box(100, 10, 100, 20, 0), 1'b0);
    // Half overlap is above 0.45.
    send_box(mk_box(0, 0, 2048, COORD_MAX, 0), 1'b0);
    // A new frame empties the list.
    send_box(mk_box(100, 100, 200, 200, 7), 1'b1);
    send_box(mk_box(100, 100, 200, 210, 7), 1'b0);
    send_box(mk_box(150, 100, 250, 200, 7), 1'b0);
    // Ratio exactly at the threshold is kept, one pixel more is suppressed.
    send_box(mk_box(1000, 0, 1256, 1, 9), 1'b0);
    send_box(mk_box(1000, 0, 1115, 1, 9), 1'b0);
    send_box(mk_box(1000, 0, 1116, 1, 9), 1'b0);
    send_box(mk_box(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX, 128), 1'b0);
    send_box(mk_box(12'hAAA, 12'h555, COORD_MAX, COORD_MAX, 8'hAA), 1'b0);
    send_box(mk_box(12'h555, 12'hAAA, 12'hFFE, 12'hFFF, 8'h55), 1'b0);
    send_box(mk_box(3000, 2000, 10, 5, 1), 1'b1);
  endtask

  // Random frames: mostly short ones, now and then one long enough to fill the list.
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned frame_left;
    logic        fs;
    bit          spread;
    box_t        bx;
    sent       = 0;
    frame_left = 0;
    spread     = 1'b0;
    while (sent < n_items || frame_left != 0) begin
      fs = 1'b0;
      if (frame_left == 0) begin
        fs         = 1'b1;
        spread     = ($urandom_range(0, 11) == 0);
        frame_left = spread ? $urandom_range(70, 80) : $urandom_range(1, 24);
        frame_boxes.delete();
      end else if ($urandom_range(0, 49) == 0) begin
        // Stray frame start in the middle of a frame.
        fs = 1'b1;
      end
      bx = make_box(spread);
      send_box(bx, fs);
      frame_boxes.insert(frame_boxes.size(), bx);
      if (frame_boxes.size() > 24) begin
        frame_boxes.delete(0);
      end
      frame_left--;
      sent++;
    end
  endtask

  // Main sequence: reset, directed cases, then random phases at several thresholds.
  initial begin
    logic [THR_W-1:0] thr_plan[9];
    logic [THR_W-1:0] thr;
    int unsigned      p;
    thr_plan = '{9'd0, 9'd256, 9'd128, 9'd1, 9'd255, 9'd0, 9'd64, 9'd200, THR_RESET};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(ITEMS_PER_PHASE);
    for (p = 0; p < 9; p++) begin
      wait_idle();
      thr = (p == 5) ? THR_W'($urandom_range(2, 254)) : thr_plan[p];
      write_threshold(thr);
      // Long receiver hold-off while candidates keep coming.
      if (p == 1 || p == 6) begin
        hold_request = 1'b1;
      end
      run_random(ITEMS_PER_PHASE);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_verdicts.size() != 0) begin
      sb.failures++;
      $display("%0d verdicts never arrived", sb.expected_verdicts.size());
    end
    if (sb.failures == 0) begin
      $display("tb_class_aware_box_nms OK");
    end else begin
      $display("tb_class_aware_box_nms NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
sv/cnms_pkg.sv
sv/cnms_iou.sv
sv/class_aware_box_nms.sv
bench/tb_class_aware_box_nms.sv
